### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled while in reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while in reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### design/afl_pkg.sv
// Package with the types and constants of the attitude filter and mixer.
`default_nettype none
package afl_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_CORDIC,
    ST_BLEND,
    ST_ERR,
    ST_MIX,
    ST_SAT,
    ST_OUT
  } state_t;

  localparam logic [2:0] REG_BLEND_WEIGHT    = 3'd0;
  localparam logic [2:0] REG_STEP_TIME       = 3'd1;
  localparam logic [2:0] REG_GAIN_ROLL       = 3'd2;
  localparam logic [2:0] REG_GAIN_PITCH      = 3'd3;
  localparam logic [2:0] REG_GAIN_ROLL_RATE  = 3'd4;
  localparam logic [2:0] REG_GAIN_PITCH_RATE = 3'd5;
  localparam logic [2:0] REG_GAIN_YAW_RATE   = 3'd6;

  // Arctangent of 2^-i in 2^-16 degree.
  function automatic logic [21:0] atan_entry(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967; 5'd2: r = 22'd919880;
      5'd3: r = 22'd466945;   5'd4: r = 22'd234378;  5'd5: r = 22'd117303;
      5'd6: r = 22'd58666;    5'd7: r = 22'd29335;   5'd8: r = 22'd14668;
      5'd9: r = 22'd7334;     5'd10: r = 22'd3667;   5'd11: r = 22'd1833;
      5'd12: r = 22'd917;     5'd13: r = 22'd458;    5'd14: r = 22'd229;
      5'd15: r = 22'd115;     5'd16: r = 22'd57;     5'd17: r = 22'd29;
      5'd18: r = 22'd14;      5'd19: r = 22'd7;      5'd20: r = 22'd4;
      5'd21: r = 22'd2;       5'd22: r = 22'd1;      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/attitude_filter_lqr_mixer.sv
// Top level: complementary attitude filter, LQR control law and motor mixer.
//
// Usage. A sensor request arrives on the s_axis channel (tdata, 160 bits,
// holds the ten input fields). The block drops s_axis_tready while it works
// and presents one result on m_axis: four motor words and two angle
// estimates in 1/128 degree. Configuration registers are written through
// cfg_we/cfg_addr/cfg_data while the block is idle.
// Sequence: with a non-zero accelerometer vector the request runs through
// the square root, two passes of the one shared CORDIC unit (pitch, then
// roll), the blend, the errors, the gain mix and the output register.
// When accel_y and accel_z are both zero the roll pass ends at once. An
// all-zero accelerometer skips the filter and goes on to the errors.
// A new request is taken only after the result has been delivered, so
// requests never overlap.
// Reset clears the angle and rate state and loads the default gains, blend weight and step time.
// When the receiver stalls the result stays in the output register and
// no new request is taken until it has been delivered.
`default_nettype none
module attitude_filter_lqr_mixer import afl_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, roll_target,
  // pitch_target, yaw_rate_target, thrust (16 bits each, lowest first)
  input  wire logic [159:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // motor_one, motor_two, motor_three, motor_four, roll_estimate,
  // pitch_estimate (16 bits each, lowest first)
  output logic [95:0]       m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [19:0]  cfg_data
);
`include "assert_macros.svh"

  // Configuration.
  logic [15:0] blend_weight, gain_roll, gain_pitch, gain_roll_rate;
  logic [15:0] gain_pitch_rate, gain_yaw_rate;
  logic [19:0] step_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight    <= 16'd64225;
      step_time       <= 20'd16777;
      gain_roll       <= 16'd34632;
      gain_pitch      <= 16'd34645;
      gain_roll_rate  <= 16'd14956;
      gain_pitch_rate <= 16'd15165;
      gain_yaw_rate   <= 16'd12962;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BLEND_WEIGHT:    blend_weight    <= cfg_data[15:0];
        REG_STEP_TIME:       step_time       <= cfg_data;
        REG_GAIN_ROLL:       gain_roll       <= cfg_data[15:0];
        REG_GAIN_PITCH:      gain_pitch      <= cfg_data[15:0];
        REG_GAIN_ROLL_RATE:  gain_roll_rate  <= cfg_data[15:0];
        REG_GAIN_PITCH_RATE: gain_pitch_rate <= cfg_data[15:0];
        REG_GAIN_YAW_RATE:   gain_yaw_rate   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Captured request.
  logic signed [15:0] ax, ay, az, gx, gy, gz, rt, pt, yt;
  logic [15:0] thr;

  // Filter state.
  logic signed [31:0] roll_angle, pitch_angle;
  logic signed [15:0] roll_rate_held, pitch_rate_held, yaw_rate_held;

  state_t state, state_next;

  // Square root, one result bit per cycle over a 60-bit radicand.
  logic [29:0] sq_rem;
  logic [29:0] sq_root;
  logic [4:0]  sq_cnt;
  logic [31:0] sq_trial;

  // Working counters and accumulators.
  logic [4:0]          cnt;
  logic                phase;        // 0 = pitch, 1 = roll
  logic signed [31:0]  acc_pitch, acc_roll;
  logic signed [63:0]  mot [4];

  // CORDIC.
  logic               cd_start, cd_done;
  logic signed [34:0] cd_y, cd_x;
  logic signed [31:0] cd_angle;

  afl_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cd_start), .y_in(cd_y), .x_in(cd_x),
    .done(cd_done), .angle(cd_angle)
  );

  // Shared multiplier: one signed 33 x 21 product per cycle, registered.
  logic signed [32:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [53:0] mul_p;
  logic               mul_v;
  logic [4:0]         mul_tag;

  // Errors, formed in ST_ERR.
  logic signed [32:0] er, ep;
  logic signed [16:0] err_r, epr, eyr;

  // Radicand kept aside for the square root.
  logic [31:0] rad;

  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_axis_tvalid && s_axis_tready) state_next = ST_SQRT;
      ST_SQRT:   if (ax == 16'sd0 && ay == 16'sd0 && az == 16'sd0) state_next = ST_ERR;
                 else if (sq_cnt == 5'd30) state_next = ST_CORDIC;
      ST_CORDIC: if (cd_done && phase) state_next = ST_BLEND;
      ST_BLEND:  if (cnt == 5'd9) state_next = ST_ERR;
      ST_ERR:    state_next = ST_MIX;
      ST_MIX:    if (cnt == 5'd6) state_next = ST_SAT;
      ST_SAT:    state_next = ST_OUT;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Multiplier operand selection by schedule step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cnt)
      5'd0: begin mul_a = {pitch_angle[31], pitch_angle}; mul_b = 21'sd4096; end
      5'd1: begin mul_a = 33'(gy); mul_b = $signed({1'b0, step_time}); end
      5'd2: begin mul_a = 33'(acc_pitch); mul_b = 21'sd4096; end
      5'd3: begin mul_a = {roll_angle[31], roll_angle}; mul_b = 21'sd4096; end
      5'd4: begin mul_a = 33'(gx); mul_b = $signed({1'b0, step_time}); end
      5'd5: begin mul_a = 33'(acc_roll); mul_b = 21'sd4096; end
      default: ;
    endcase
    if (state == ST_MIX) begin
      unique case (cnt)
        5'd0: begin mul_a = er; mul_b = $signed({5'd0, gain_roll}); end
        5'd1: begin mul_a = ep; mul_b = $signed({5'd0, gain_pitch}); end
        5'd2: begin mul_a = 33'(err_r); mul_b = $signed({5'd0, gain_roll_rate}); end
        5'd3: begin mul_a = 33'(epr); mul_b = $signed({5'd0, gain_pitch_rate}); end
        5'd4: begin mul_a = 33'(eyr); mul_b = $signed({5'd0, gain_yaw_rate}); end
        default: ;
      endcase
    end
  end

  // Blend words: the gyro term sum times gamma and the accel term times 1-gamma
  // need a second multiply, done on the registered partial sums.
  logic signed [63:0] gyro_sum_p, gyro_sum_r;
  logic signed [63:0] accs_p, accs_r;
  logic signed [63:0] blend_t;
  logic signed [63:0] blend_r;
  logic signed [31:0] blend_sat;
  logic [16:0]        g_c;

  assign g_c = 17'd65536 - {1'b0, blend_weight};

  always_comb begin
    blend_r   = (blend_t + 64'sd134217728) >>> 28;
    if (blend_r > 64'sd2147483647)       blend_sat = 32'h7FFF_FFFF;
    else if (blend_r < -64'sd2147483648) blend_sat = 32'h8000_0000;
    else                                 blend_sat = blend_r[31:0];
  end

  // Second-stage products of the blend: 64-bit sum times 17-bit weight, formed
  // from a low 24-bit half and a high half of the sum.
  logic signed [63:0] bl_op;
  logic [16:0]        bl_w;
  logic signed [63:0] bl_lo, bl_hi;
  assign bl_lo = $signed({40'd0, bl_op[23:0]}) * $signed({47'd0, bl_w});
  assign bl_hi = (bl_op >>> 24) * $signed({47'd0, bl_w});

  logic signed [63:0] bl_hi_r;

  logic signed [63:0] mot_next [4];
  logic signed [63:0] term;
  logic [15:0] motor_w [4];

  always_comb begin
    term = 64'(mul_p);
    if (mul_tag >= 5'd2) term = term <<< 12;
    for (int k = 0; k < 4; k++) mot_next[k] = mot[k];
    unique case (mul_tag)
      5'd0: begin mot_next[0] = mot[0] - term; mot_next[1] = mot[1] - term;
                  mot_next[2] = mot[2] + term; mot_next[3] = mot[3] + term; end
      5'd1: begin mot_next[0] = mot[0] - term; mot_next[1] = mot[1] + term;
                  mot_next[2] = mot[2] + term; mot_next[3] = mot[3] - term; end
      5'd2: begin mot_next[0] = mot[0] - term; mot_next[1] = mot[1] - term;
                  mot_next[2] = mot[2] + term; mot_next[3] = mot[3] + term; end
      5'd3: begin mot_next[0] = mot[0] - term; mot_next[1] = mot[1] + term;
                  mot_next[2] = mot[2] + term; mot_next[3] = mot[3] - term; end
      5'd4: begin mot_next[0] = mot[0] - term; mot_next[1] = mot[1] + term;
                  mot_next[2] = mot[2] - term; mot_next[3] = mot[3] + term; end
      default: ;
    endcase
    for (int k = 0; k < 4; k++) begin
      if (mot[k] < 0)                          motor_w[k] = 16'd0;
      else if ((mot[k] >>> 24) > 64'sd65535)   motor_w[k] = 16'hFFFF;
      else                                     motor_w[k] = mot[k][39:24];
    end
  end

  function automatic logic [15:0] port_angle(input logic signed [31:0] a);
    logic signed [22:0] q;
    q = 23'(a >>> 9);
    if (q > 23'sd32767)       return 16'h7FFF;
    else if (q < -23'sd32768) return 16'h8000;
    else                      return q[15:0];
  endfunction

  // The pitch pass starts as the square root finishes; the roll pass starts
  // from the CORDIC state once the pitch angle is in.
  assign cd_y = (state == ST_SQRT) ? -(35'(ax) <<< 14) : (35'(ay) <<< 14);
  assign cd_x = (state == ST_SQRT) ? $signed({5'd0, sq_root}) : (35'(az) <<< 14);
  assign cd_start = (state == ST_SQRT && state_next == ST_CORDIC) ||
                    (state == ST_CORDIC && cd_done && !phase);
  assign sq_trial = {sq_root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid   <= 1'b0;
      roll_angle      <= '0;
      pitch_angle     <= '0;
      roll_rate_held  <= '0;
      pitch_rate_held <= '0;
      yaw_rate_held   <= '0;
      mul_v           <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      mul_v <= (state == ST_MIX) && (cnt < 5'd5);
      unique case (state)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          ax <= s_axis_tdata[15:0];    ay <= s_axis_tdata[31:16];
          az <= s_axis_tdata[47:32];   gx <= s_axis_tdata[63:48];
          gy <= s_axis_tdata[79:64];   gz <= s_axis_tdata[95:80];
          rt <= s_axis_tdata[111:96];  pt <= s_axis_tdata[127:112];
          yt <= s_axis_tdata[143:128]; thr <= s_axis_tdata[159:144];
          sq_cnt <= 5'd0;
          sq_root <= '0;
          phase <= 1'b0;
          cnt <= 5'd0;
          rad <= 32'($signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]))
               + 32'($signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[47:32]));
          sq_rem <= '0;
        end
        ST_SQRT: begin
          // Radicand is rad << 28; consume two radicand bits each cycle.
          logic [1:0] pair;
          logic [31:0] r;
          pair = (sq_cnt < 5'd16) ? rad[5'd30 - {sq_cnt[3:0], 1'b0} +: 2] : 2'b00;
          r = {sq_rem, pair};
          if (sq_cnt != 5'd30) begin
            if (r >= sq_trial) begin
              sq_rem  <= 30'(r - sq_trial);
              sq_root <= {sq_root[28:0], 1'b1};
            end else begin
              sq_rem  <= r[29:0];
              sq_root <= {sq_root[28:0], 1'b0};
            end
            sq_cnt <= sq_cnt + 5'd1;
          end
        end
        ST_CORDIC: if (cd_done) begin
          if (!phase) acc_pitch <= cd_angle;
          else        acc_roll  <= cd_angle;
          phase <= 1'b1;
        end
        ST_BLEND: begin
          // Step schedule: gather the gyro and accelerometer sums, weight them
          // with split multiplies, pitch first, then roll, and last hold the gyro rates.
          cnt <= cnt + 5'd1;
          unique case (cnt)
            5'd0: begin
              gyro_sum_p <= 64'(pitch_angle) * 64'sd4096
                          + 64'(gy) * $signed({44'd0, step_time});
              accs_p     <= 64'(acc_pitch) * 64'sd4096;
              gyro_sum_r <= 64'(roll_angle) * 64'sd4096
                          + 64'(gx) * $signed({44'd0, step_time});
              accs_r     <= 64'(acc_roll) * 64'sd4096;
            end
            5'd1: begin bl_op <= gyro_sum_p; bl_w <= {1'b0, blend_weight}; end
            5'd2: begin bl_hi_r <= bl_hi; blend_t <= bl_lo;
                        bl_op <= accs_p; bl_w <= g_c; end
            5'd3: begin blend_t <= blend_t + (bl_hi_r <<< 24) + bl_lo + (bl_hi <<< 24); end
            5'd4: begin pitch_angle <= blend_sat;
                        bl_op <= gyro_sum_r; bl_w <= {1'b0, blend_weight}; end
            5'd5: begin bl_hi_r <= bl_hi; blend_t <= bl_lo;
                        bl_op <= accs_r; bl_w <= g_c; end
            5'd6: begin blend_t <= blend_t + (bl_hi_r <<< 24) + bl_lo + (bl_hi <<< 24); end
            5'd7: roll_angle <= blend_sat;
            5'd8: begin
              roll_rate_held  <= gx;
              pitch_rate_held <= gy;
              yaw_rate_held   <= gz;
            end
            default: ;
          endcase
        end
        ST_ERR: begin
          er    <= -(33'(roll_angle) + (33'(rt) <<< 9));
          ep    <= -(33'(pitch_angle) - (33'(pt) <<< 9));
          err_r <= -17'(roll_rate_held);
          epr   <= -17'(pitch_rate_held);
          eyr   <= -(17'(yaw_rate_held) - 17'(yt));
          for (int k = 0; k < 4; k++) mot[k] <= $signed({24'd0, thr, 24'd0});
          cnt <= 5'd0;
        end
        ST_MIX: begin
          cnt <= cnt + 5'd1;
          if (cnt < 5'd5) begin
            mul_p   <= mul_a * mul_b;
            mul_tag <= cnt;
          end
          if (mul_v) for (int k = 0; k < 4; k++) mot[k] <= mot_next[k];
        end
        ST_SAT: ;
        ST_OUT: begin
          m_axis_tdata <= {port_angle(pitch_angle), port_angle(roll_angle),
                           motor_w[3], motor_w[2], motor_w[1], motor_w[0]};
          m_axis_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `CHK_IMPLY(a_ready_idle, clk, rst, s_axis_tready, state == ST_IDLE, "ready outside idle")
  `CHK_IMPLY(a_no_ready_busy, clk, rst, m_axis_tvalid, !s_axis_tready, "accepted with result pending")
  `CHK_NEXT(a_out_valid, clk, rst, state == ST_OUT, m_axis_tvalid, "result not presented")

endmodule
`default_nettype wire

### design/afl_cordic.sv
// Shared CORDIC vectoring unit: one rotation step per clock.
`default_nettype none
module afl_cordic import afl_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [34:0] y_in,
  input  wire logic signed [34:0] x_in,
  output logic                    done,
  output logic signed [31:0]      angle
);
  localparam int CW = 40;
  localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

  logic signed [CW-1:0] x, y;
  logic signed [31:0]   z;
  logic [4:0]           step;
  logic                 busy;

  assign angle = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= start ? (x_in == 35'sd0 && y_in == 35'sd0) : (busy && step == LAST);
      if (start) begin
        step <= 5'd0;
        if (x_in == 35'sd0 && y_in == 35'sd0) begin
          z    <= 32'sd0;
        end else begin
          busy <= 1'b1;
          if (x_in < 0) begin
            z <= (y_in >= 0) ? 32'sd11796480 : -32'sd11796480;
            x <= -CW'(x_in);
            y <= -CW'(y_in);
          end else begin
            z <= 32'sd0;
            x <= CW'(x_in);
            y <= CW'(y_in);
          end
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          z <= z + $signed({10'd0, atan_entry(step)});
        end else begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          z <= z - $signed({10'd0, atan_entry(step)});
        end
        step <= step + 5'd1;
        if (step == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire
